/* design/kvs_pkg.sv */
// ----------------------------------------------------------------------------
// kvs_pkg: shared types and constants of the keyframe vector sampler
// Store sizes, field widths, command/status structs and code constants used
// by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kvs_pkg;

	localparam int TIME_DEPTH  = 1024;
	localparam int VALUE_DEPTH = 4096;
	localparam int FRACT_BITS  = 16;
	localparam int TIME_FB     = 16;   // time format is Q16.16

	localparam int TIME_AW  = $clog2(TIME_DEPTH);
	localparam int VALUE_AW = $clog2(VALUE_DEPTH);

	localparam int KIND_W = 2;
	localparam int ADDR_W = 12;
	localparam int DATA_W = 32;
	localparam int KOFF_W = 10;
	localparam int KCNT_W = 11;
	localparam int VOFF_W = 12;
	localparam int MODE_W = 2;
	localparam int KIDX_W = KCNT_W + 1;
	localparam int VIDX_W = VOFF_W + 2;
	localparam int VEC_W  = 3 * DATA_W;

	localparam int MUL_W  = 36;
	localparam int PROD_W = 2 * MUL_W;
	localparam int H_W    = FRACT_BITS + 4;

	localparam int CALC_STEPS = 12;
	localparam int CNT_W = $clog2(FRACT_BITS > CALC_STEPS ? FRACT_BITS : CALC_STEPS);

	localparam logic [KIND_W-1:0] KIND_TIME  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CUBIC  = 2'd2;

	localparam logic [1:0] TS_FIRST = 2'd0;
	localparam logic [1:0] TS_LAST  = 2'd1;
	localparam logic [1:0] TS_IDX   = 2'd2;

	localparam logic [1:0] VS_FIRST = 2'd0;
	localparam logic [1:0] VS_LAST  = 2'd1;
	localparam logic [1:0] VS_SEG   = 2'd2;

	localparam logic [1:0] SL_P0 = 2'd0;
	localparam logic [1:0] SL_M0 = 2'd1;
	localparam logic [1:0] SL_M1 = 2'd2;
	localparam logic [1:0] SL_P1 = 2'd3;

	localparam logic [3:0] MOP_NONE  = 4'd0;
	localparam logic [3:0] MOP_SS    = 4'd1;
	localparam logic [3:0] MOP_S2S   = 4'd2;
	localparam logic [3:0] MOP_LIN   = 4'd3;
	localparam logic [3:0] MOP_P0H00 = 4'd4;
	localparam logic [3:0] MOP_P1H01 = 4'd5;
	localparam logic [3:0] MOP_M0H10 = 4'd6;
	localparam logic [3:0] MOP_M1H11 = 4'd7;
	localparam logic [3:0] MOP_TDUR  = 4'd8;

	localparam logic [3:0] AOP_NONE = 4'd0;
	localparam logic [3:0] AOP_S2   = 4'd1;
	localparam logic [3:0] AOP_S3   = 4'd2;
	localparam logic [3:0] AOP_H    = 4'd3;
	localparam logic [3:0] AOP_LOAD = 4'd4;
	localparam logic [3:0] AOP_ADD  = 4'd5;
	localparam logic [3:0] AOP_T0   = 4'd6;
	localparam logic [3:0] AOP_T1   = 4'd7;
	localparam logic [3:0] AOP_FINL = 4'd8;
	localparam logic [3:0] AOP_FINC = 4'd9;

	localparam logic [1:0] OS_ZERO = 2'd0;
	localparam logic [1:0] OS_P0   = 2'd1;
	localparam logic [1:0] OS_CALC = 2'd2;

	localparam logic [1:0] COMP_LAST = 2'd2;

	typedef struct packed {
		logic       wr;
		logic       q_ld;
		logic [1:0] tsel;
		logic       prev_ld;
		logic       idx_init;
		logic       idx_inc;
		logic       seg_ld;
		logic       div_step;
		logic       vrd;
		logic [1:0] vsel;
		logic [2:0] voffs;
		logic [1:0] vslot;
		logic [3:0] mop;
		logic [3:0] aop;
		logic [1:0] comp;
		logic       out_ld;
		logic [1:0] osel;
	} cmd_t;

	typedef struct packed {
		logic              count_zero;
		logic              count_one;
		logic              le_first;
		logic              ge_last;
		logic              hit;
		logic              idx_last;
		logic [MODE_W-1:0] mode;
	} status_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(33'sh0_7FFF_FFFF);
		lo = PROD_W'(33'sh1_8000_0000);
		if (v > hi) begin
			sat32 = hi[DATA_W-1:0];
		end else if (v < lo) begin
			sat32 = lo[DATA_W-1:0];
		end else begin
			sat32 = v[DATA_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

/* design/kvs_ram.sv */
// ----------------------------------------------------------------------------
// kvs_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

/* design/kvs_dp.sv */
// ----------------------------------------------------------------------------
// kvs_dp: sampler datapath
// Key and value stores, interval search compare, restoring divider, shared
// multiplier with accumulator, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_dp (
	input  wire logic                          clk,
	input  wire kvs_pkg::cmd_t                 cmd,
	output kvs_pkg::status_t                   sts,
	input  wire logic [1:0]                    kind,
	input  wire logic [11:0]                   address,
	input  wire logic [31:0]                   load_time,
	input  wire logic signed [31:0]            load_x,
	input  wire logic signed [31:0]            load_y,
	input  wire logic signed [31:0]            load_z,
	input  wire logic [9:0]                    key_offset,
	input  wire logic [10:0]                   key_count,
	input  wire logic [11:0]                   value_offset,
	input  wire logic [1:0]                    interp_mode,
	input  wire logic [31:0]                   sample_time,
	output logic signed [31:0]                 out_x,
	output logic signed [31:0]                 out_y,
	output logic signed [31:0]                 out_z,
	output logic                               found
);

	import kvs_pkg::*;

	logic [KOFF_W-1:0] koff_q;
	logic [KCNT_W-1:0] count_q;
	logic [VOFF_W-1:0] voff_q;
	logic [MODE_W-1:0] mode_q;
	logic [DATA_W-1:0] time_q;
	logic [DATA_W-1:0] prev_q;
	logic [KCNT_W-1:0] idx_q;
	logic [DATA_W-1:0] dur_q;
	logic [DATA_W-1:0] rem_q;
	logic [FRACT_BITS-1:0] quo_q;
	logic [VIDX_W-1:0] vbase_q;

	logic [KIDX_W-1:0] tidx;
	logic              t_oor;
	logic              t_oor_s1;
	logic              t_we;
	logic [DATA_W-1:0] t_rdata;
	logic [DATA_W-1:0] tdata;

	logic [VIDX_W-1:0] vidx;
	logic [VIDX_W-1:0] cm1;
	logic              v_oor;
	logic              v_oor_s1;
	logic              vrd_s1;
	logic [1:0]        vslot_s1;
	logic              v_we;
	logic [VEC_W-1:0]  v_rdata;
	logic [VEC_W-1:0]  vdata;
	logic [VEC_W-1:0]  slot_q [4];

	logic signed [DATA_W-1:0] p0c, p1c, m0c, m1c;
	logic signed [MUL_W-1:0]  ma, mb;
	logic signed [PROD_W-1:0] mul_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] vals_q;
	logic signed [MUL_W-1:0]  t_q;
	logic [FRACT_BITS-1:0]    s2_q, s3_q;
	logic signed [H_W-1:0]    h00_q, h10_q, h01_q, h11_q;
	logic signed [H_W-1:0]    sv, sv2, sv3, one;
	logic signed [DATA_W-1:0] rx_q, ry_q, rz_q;
	logic signed [DATA_W-1:0] fin;
	logic [DATA_W:0]          r2;
	logic                     ge;
	logic                     cubic;

	function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] v,
		input int sh);
		logic signed [PROD_W-1:0] half;
		logic signed [PROD_W-1:0] s;
		half = PROD_W'(1) <<< (sh - 1);
		s = v + half;
		rnd = s >>> sh;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick(input logic [VEC_W-1:0] w,
		input logic [1:0] c);
		case (c)
			2'd0:    pick = w[DATA_W-1:0];
			2'd1:    pick = w[2*DATA_W-1:DATA_W];
			default: pick = w[3*DATA_W-1:2*DATA_W];
		endcase
	endfunction

	assign cubic = (mode_q == MODE_CUBIC);

	// key time store
	always_comb begin
		case (cmd.tsel)
			TS_FIRST: tidx = KIDX_W'(koff_q);
			TS_LAST:  tidx = KIDX_W'(koff_q) + KIDX_W'(count_q) - KIDX_W'(1);
			default:  tidx = KIDX_W'(koff_q) + KIDX_W'(idx_q);
		endcase
	end
	assign t_oor = 32'(tidx) >= 32'(TIME_DEPTH);
	assign t_we  = cmd.wr && (kind == KIND_TIME) && (32'(address) < 32'(TIME_DEPTH));

	kvs_ram #(.WIDTH(DATA_W), .DEPTH(TIME_DEPTH)) u_tram (
		.clk   (clk),
		.we    (t_we),
		.addr  (t_we ? TIME_AW'(address) : TIME_AW'(tidx)),
		.wdata (load_time),
		.rdata (t_rdata)
	);

	assign tdata = t_oor_s1 ? '0 : t_rdata;

	// value store
	assign cm1 = VIDX_W'(count_q) - VIDX_W'(1);
	always_comb begin
		case (cmd.vsel)
			VS_FIRST: vidx = VIDX_W'(voff_q) + (cubic ? VIDX_W'(1) : '0);
			VS_LAST:  vidx = VIDX_W'(voff_q) + (cubic ? (cm1 << 1) + cm1 + VIDX_W'(1) : cm1);
			default:  vidx = vbase_q + VIDX_W'(cmd.voffs);
		endcase
	end
	assign v_oor = 32'(vidx) >= 32'(VALUE_DEPTH);
	assign v_we  = cmd.wr && (kind == KIND_VALUE) && (32'(address) < 32'(VALUE_DEPTH));

	kvs_ram #(.WIDTH(VEC_W), .DEPTH(VALUE_DEPTH)) u_vram (
		.clk   (clk),
		.we    (v_we),
		.addr  (v_we ? VALUE_AW'(address) : VALUE_AW'(vidx)),
		.wdata ({load_z, load_y, load_x}),
		.rdata (v_rdata)
	);

	assign vdata = v_oor_s1 ? '0 : v_rdata;

	// status
	always_comb begin
		sts.count_zero = (count_q == '0);
		sts.count_one  = (count_q == KCNT_W'(1));
		sts.le_first   = (time_q <= tdata);
		sts.ge_last    = (time_q >= tdata);
		sts.hit        = (prev_q <= time_q) && (tdata > time_q);
		sts.idx_last   = (idx_q == count_q - KCNT_W'(1));
		sts.mode       = mode_q;
	end

	assign r2 = {rem_q, 1'b0};
	assign ge = (r2 >= {1'b0, dur_q});

	always_ff @(posedge clk) begin
		t_oor_s1 <= t_oor;
		v_oor_s1 <= v_oor;
		vrd_s1   <= cmd.vrd;
		vslot_s1 <= cmd.vslot;
		if (cmd.q_ld) begin
			koff_q  <= key_offset;
			count_q <= key_count;
			voff_q  <= value_offset;
			mode_q  <= interp_mode;
			time_q  <= sample_time;
		end
		if (cmd.prev_ld) begin
			prev_q <= tdata;
		end
		if (cmd.idx_init) begin
			idx_q <= KCNT_W'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + KCNT_W'(1);
		end
		if (cmd.seg_ld) begin
			// interval is [prev, tdata); idx - 1 is its key number
			dur_q   <= tdata - prev_q;
			rem_q   <= time_q - prev_q;
			quo_q   <= '0;
			vbase_q <= VIDX_W'(voff_q) + (cubic ?
				VIDX_W'(3) * (VIDX_W'(idx_q) - VIDX_W'(1)) : VIDX_W'(idx_q) - VIDX_W'(1));
		end else if (cmd.div_step) begin
			rem_q <= ge ? DATA_W'(r2 - {1'b0, dur_q}) : r2[DATA_W-1:0];
			quo_q <= {quo_q[FRACT_BITS-2:0], ge};
		end
		if (vrd_s1) begin
			slot_q[vslot_s1] <= vdata;
		end
	end

	// multiplier operands
	always_comb begin
		p0c = pick(slot_q[SL_P0], cmd.comp);
		p1c = pick(slot_q[SL_P1], cmd.comp);
		m0c = pick(slot_q[SL_M0], cmd.comp);
		m1c = pick(slot_q[SL_M1], cmd.comp);
		ma  = '0;
		mb  = '0;
		case (cmd.mop)
			MOP_SS: begin
				ma = MUL_W'(quo_q);
				mb = MUL_W'(quo_q);
			end
			MOP_S2S: begin
				ma = MUL_W'(s2_q);
				mb = MUL_W'(quo_q);
			end
			MOP_LIN: begin
				ma = MUL_W'(p1c) - MUL_W'(p0c);
				mb = MUL_W'(quo_q);
			end
			MOP_P0H00: begin
				ma = MUL_W'(p0c);
				mb = MUL_W'(h00_q);
			end
			MOP_P1H01: begin
				ma = MUL_W'(p1c);
				mb = MUL_W'(h01_q);
			end
			MOP_M0H10: begin
				ma = MUL_W'(m0c);
				mb = MUL_W'(h10_q);
			end
			MOP_M1H11: begin
				ma = MUL_W'(m1c);
				mb = MUL_W'(h11_q);
			end
			MOP_TDUR: begin
				ma = t_q;
				mb = MUL_W'(dur_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		sv  = H_W'(quo_q);
		sv2 = H_W'(s2_q);
		sv3 = H_W'(s3_q);
		one = H_W'(1) <<< FRACT_BITS;
	end

	assign fin = (cmd.aop == AOP_FINL) ? sat32(PROD_W'(p0c) + rnd(mul_q, FRACT_BITS))
		: sat32(vals_q + rnd(mul_q, TIME_FB));

	always_ff @(posedge clk) begin
		mul_q <= ma * mb;
		case (cmd.aop)
			AOP_S2: s2_q <= mul_q[FRACT_BITS +: FRACT_BITS];
			AOP_S3: s3_q <= mul_q[FRACT_BITS +: FRACT_BITS];
			AOP_H: begin
				h00_q <= (sv3 <<< 1) - (sv2 <<< 1) - sv2 + one;
				h10_q <= sv3 - (sv2 <<< 1) + sv;
				h01_q <= (sv2 <<< 1) + sv2 - (sv3 <<< 1);
				h11_q <= sv3 - sv2;
			end
			AOP_LOAD: acc_q <= mul_q;
			AOP_ADD:  acc_q <= acc_q + mul_q;
			AOP_T0: begin
				t_q    <= MUL_W'(rnd(mul_q, FRACT_BITS));
				vals_q <= rnd(acc_q, FRACT_BITS);
			end
			AOP_T1: t_q <= t_q + MUL_W'(rnd(mul_q, FRACT_BITS));
			AOP_FINL, AOP_FINC: begin
				case (cmd.comp)
					2'd0:    rx_q <= fin;
					2'd1:    ry_q <= fin;
					default: rz_q <= fin;
				endcase
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			case (cmd.osel)
				OS_P0: begin
					out_x <= pick(slot_q[SL_P0], 2'd0);
					out_y <= pick(slot_q[SL_P0], 2'd1);
					out_z <= pick(slot_q[SL_P0], 2'd2);
					found <= 1'b1;
				end
				OS_CALC: begin
					out_x <= rx_q;
					out_y <= ry_q;
					out_z <= rz_q;
					found <= 1'b1;
				end
				default: begin
					out_x <= '0;
					out_y <= '0;
					out_z <= '0;
					found <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/kvs_ctrl.sv */
// ----------------------------------------------------------------------------
// kvs_ctrl: sampler controller
// Sequences loads, the key search, the divider, value reads and the
// multiply micro-program, and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [1:0]        kind,
	output logic                   result_valid,
	input  wire logic              result_ready,
	input  wire kvs_pkg::status_t  sts,
	output kvs_pkg::cmd_t          cmd
);

	import kvs_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FIRST  = 4'd1;
	localparam logic [3:0] S_WFIRST = 4'd2;
	localparam logic [3:0] S_WLAST  = 4'd3;
	localparam logic [3:0] S_SCAN   = 4'd4;
	localparam logic [3:0] S_WSCAN  = 4'd5;
	localparam logic [3:0] S_SEG    = 4'd6;
	localparam logic [3:0] S_DIV    = 4'd7;
	localparam logic [3:0] S_VRD    = 4'd8;
	localparam logic [3:0] S_VLAND  = 4'd9;
	localparam logic [3:0] S_LAND   = 4'd10;
	localparam logic [3:0] S_CALC   = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(FRACT_BITS - 1);
	localparam logic [CNT_W-1:0] CUB_COMP0  = CNT_W'(5);
	localparam logic [CNT_W-1:0] CUB_LAST   = CNT_W'(CALC_STEPS - 1);

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       comp_q, comp_d;
	logic [1:0]       osel_q, osel_d;
	logic             cubic;
	logic             calc_end;

	assign cubic = (sts.mode == MODE_CUBIC);

	always_comb begin
		cmd        = '0;
		cmd.comp   = comp_q;
		cmd.osel   = osel_q;
		state_d    = state_q;
		cnt_d      = cnt_q;
		comp_d     = comp_q;
		osel_d     = osel_q;
		item_ready = 1'b0;
		calc_end   = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (kind == KIND_QUERY) begin
						cmd.q_ld = 1'b1;
						state_d  = S_FIRST;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			S_FIRST: begin
				if (sts.count_zero) begin
					osel_d  = OS_ZERO;
					state_d = S_DONE;
				end else begin
					cmd.tsel = TS_FIRST;
					state_d  = S_WFIRST;
				end
			end
			S_WFIRST: begin
				cmd.prev_ld = 1'b1;
				if (sts.count_one || sts.le_first) begin
					cmd.vrd   = 1'b1;
					cmd.vsel  = VS_FIRST;
					cmd.vslot = SL_P0;
					osel_d    = OS_P0;
					state_d   = S_LAND;
				end else begin
					cmd.tsel = TS_LAST;
					state_d  = S_WLAST;
				end
			end
			S_WLAST: begin
				if (sts.ge_last) begin
					cmd.vrd   = 1'b1;
					cmd.vsel  = VS_LAST;
					cmd.vslot = SL_P0;
					osel_d    = OS_P0;
					state_d   = S_LAND;
				end else begin
					cmd.idx_init = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.tsel = TS_IDX;
				state_d  = S_WSCAN;
			end
			S_WSCAN: begin
				if (sts.hit) begin
					cmd.seg_ld = 1'b1;
					state_d    = S_SEG;
				end else if (sts.idx_last) begin
					osel_d  = OS_ZERO;
					state_d = S_DONE;
				end else begin
					cmd.prev_ld = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SEG: begin
				cnt_d  = '0;
				comp_d = '0;
				case (sts.mode)
					MODE_LINEAR, MODE_CUBIC: state_d = S_DIV;
					MODE_STEP: begin
						cmd.vrd   = 1'b1;
						cmd.vsel  = VS_SEG;
						cmd.vslot = SL_P0;
						osel_d    = OS_P0;
						state_d   = S_LAND;
					end
					default: begin
						osel_d  = OS_ZERO;
						state_d = S_DONE;
					end
				endcase
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNT_W'(1);
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = S_VRD;
				end
			end
			S_VRD: begin
				cmd.vrd  = 1'b1;
				cmd.vsel = VS_SEG;
				cnt_d    = cnt_q + CNT_W'(1);
				if (cubic) begin
					// in-tangent, value, out-tangent per key: p0 m0 m1 p1 at +1..+4
					cmd.voffs = 3'(cnt_q) + 3'd1;
					cmd.vslot = 2'(cnt_q);
					if (cnt_q == CNT_W'(3)) begin
						cnt_d   = '0;
						state_d = S_VLAND;
					end
				end else begin
					cmd.voffs = 3'(cnt_q);
					cmd.vslot = (cnt_q == '0) ? SL_P0 : SL_P1;
					if (cnt_q == CNT_W'(1)) begin
						cnt_d   = '0;
						state_d = S_VLAND;
					end
				end
			end
			S_VLAND: state_d = S_CALC;
			S_LAND:  state_d = S_DONE;
			S_CALC: begin
				if (cubic) begin
					case (cnt_q)
						CNT_W'(0): cmd.mop = MOP_SS;
						CNT_W'(1): cmd.aop = AOP_S2;
						CNT_W'(2): cmd.mop = MOP_S2S;
						CNT_W'(3): cmd.aop = AOP_S3;
						CNT_W'(4): cmd.aop = AOP_H;
						CNT_W'(5): cmd.mop = MOP_P0H00;
						CNT_W'(6): begin
							cmd.mop = MOP_P1H01;
							cmd.aop = AOP_LOAD;
						end
						CNT_W'(7): begin
							cmd.mop = MOP_M0H10;
							cmd.aop = AOP_ADD;
						end
						CNT_W'(8): begin
							cmd.mop = MOP_M1H11;
							cmd.aop = AOP_T0;
						end
						CNT_W'(9):  cmd.aop = AOP_T1;
						CNT_W'(10): cmd.mop = MOP_TDUR;
						CNT_W'(11): cmd.aop = AOP_FINC;
						default: ;
					endcase
					calc_end = (cnt_q == CUB_LAST);
				end else begin
					if (cnt_q == '0) begin
						cmd.mop = MOP_LIN;
					end else begin
						cmd.aop = AOP_FINL;
					end
					calc_end = (cnt_q == CNT_W'(1));
				end
				cnt_d = cnt_q + CNT_W'(1);
				if (calc_end) begin
					if (comp_q == COMP_LAST) begin
						osel_d  = OS_CALC;
						state_d = S_DONE;
					end else begin
						comp_d = comp_q + 2'd1;
						cnt_d  = cubic ? CUB_COMP0 : '0;
					end
				end
			end
			S_DONE: begin
				if (!result_valid) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			comp_q       <= '0;
			osel_q       <= OS_ZERO;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
			osel_q  <= osel_d;
			if (cmd.out_ld) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/keyframe_vector_sampler.sv */
// ----------------------------------------------------------------------------
// keyframe_vector_sampler: keyframe animation sampler for 3-vectors
// Stores key times and vector values, answers linear, step and cubic Hermite
// sample queries with one result beat each.
// ----------------------------------------------------------------------------
//  channel | handshake                 | beat
//  item    | item_valid / item_ready   | kind, address, load_*, query fields
//  result  | result_valid / result_ready | out_x, out_y, out_z, found
//
//  Load beats are written from the idle state. A query runs through a
//  controller: each key compare in the interval search is a key time read
//  and then a compare, then FRACT_BITS divider steps, value reads and a shared
//  multiplier program. The result register lets the next item in while a
//  result waits; a query holds in its last state until the result register
//  is free.
//  arst_n clears the controller; stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_vector_sampler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [11:0]        address,
	input  wire logic [31:0]        load_time,
	input  wire logic signed [31:0] load_x,
	input  wire logic signed [31:0] load_y,
	input  wire logic signed [31:0] load_z,
	input  wire logic [9:0]         key_offset,
	input  wire logic [10:0]        key_count,
	input  wire logic [11:0]        value_offset,
	input  wire logic [1:0]         interp_mode,
	input  wire logic [31:0]        sample_time,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic                    found
);

	import kvs_pkg::*;

	cmd_t    cmd;
	status_t sts;

	kvs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	kvs_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.address      (address),
		.load_time    (load_time),
		.load_x       (load_x),
		.load_y       (load_y),
		.load_z       (load_z),
		.key_offset   (key_offset),
		.key_count    (key_count),
		.value_offset (value_offset),
		.interp_mode  (interp_mode),
		.sample_time  (sample_time),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.found        (found)
	);

endmodule

`default_nettype wire

/* design/kvs_checker.sv */
// ----------------------------------------------------------------------------
// kvs_checker: port-level checks of the sampler
// Watches the top-level ports; bound to keyframe_vector_sampler.
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_ready,
	input wire logic [1:0]         kind,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire logic signed [31:0] out_x,
	input wire logic signed [31:0] out_y,
	input wire logic signed [31:0] out_z,
	input wire logic               found
);

	import kvs_pkg::*;

	// a query occupies the block, so the next beat waits
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && kind == KIND_QUERY |=> !item_ready)
		else $error("item taken right after a query");

	// a fallback result carries a zero vector
	a_zero_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> out_x == 0 && out_y == 0 && out_z == 0)
		else $error("nonzero vector with found low");

	// a result appears only at the end of a query
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result without a query in flight");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_x) && $stable(found))
		else $error("stalled result beat changed");

endmodule

bind keyframe_vector_sampler kvs_checker u_kvs_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keyframe_vector_sampler
// Loads key times and vectors, then samples channels in linear, step and
// cubic mode. A directed table comes first, then random channels with queries
// around their keys plus random noise beats. Each result is compared against
// a table value or the in-bench sampler model, under three idle/stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
	import kvs_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SHOW_MAX    = 10;

	typedef struct {
		logic [1:0]  kind;
		logic [11:0] addr;
		logic [31:0] ltime;
		logic [31:0] lx, ly, lz;
		logic [9:0]  koff;
		logic [10:0] kcnt;
		logic [11:0] voff;
		logic [1:0]  mode;
		logic [31:0] stime;
	} beat_t;

	typedef struct packed {
		logic [31:0] x, y, z;
		logic        fnd;
	} sample_t;

	typedef struct {
		beat_t   b;
		bit      typed;
		sample_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid, item_ready;
	logic [1:0] kind;
	logic [11:0] address;
	logic [31:0] load_time;
	logic signed [31:0] load_x, load_y, load_z;
	logic [9:0] key_offset;
	logic [10:0] key_count;
	logic [11:0] value_offset;
	logic [1:0] interp_mode;
	logic [31:0] sample_time;
	logic result_valid, result_ready;
	logic signed [31:0] out_x, out_y, out_z;
	logic found;

	keyframe_vector_sampler dut (.*);

	always #1 clk = ~clk;

	// bench copy of the stores, plus written flags so no unwritten entry is read
	logic [31:0] key_time_mem [TIME_DEPTH];
	logic [31:0] vec_mem [VALUE_DEPTH][3];
	bit time_set [TIME_DEPTH];
	bit vec_set [VALUE_DEPTH];

	sample_t pending_samples[$];
	row_t    directed[$];
	int src_idle, snk_idle;
	int n_sent, n_loads, n_queries, n_checked, n_cubic, n_mismatch;
	int cycles;

	// ---------------- sampler model ----------------
	function automatic logic [31:0] key_rd(input int idx, inout bit bad);
		if (idx >= TIME_DEPTH) return 32'd0;
		if (!time_set[idx]) bad = 1'b1;
		return key_time_mem[idx];
	endfunction

	function automatic longint comp_rd(input int idx, input int c, inout bit bad);
		if (idx >= VALUE_DEPTH) return 0;
		if (!vec_set[idx]) bad = 1'b1;
		return longint'(signed'(vec_mem[idx][c]));
	endfunction

	function automatic longint rnd_shift(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic longint hermite_eval(input longint p0, m0, p1, m1, s, dur);
		longint one, s2, s3, h00, h10, h01, h11, vals, t0, t1;
		one = longint'(1) <<< FRACT_BITS;
		s2 = (s * s) >>> FRACT_BITS;
		s3 = (s2 * s) >>> FRACT_BITS;
		h00 = 2 * s3 - 3 * s2 + one;
		h10 = s3 - 2 * s2 + s;
		h01 = -2 * s3 + 3 * s2;
		h11 = s3 - s2;
		vals = rnd_shift(p0 * h00 + p1 * h01, FRACT_BITS);
		t0 = rnd_shift(m0 * h10, FRACT_BITS);
		t1 = rnd_shift(m1 * h11, FRACT_BITS);
		return vals + rnd_shift(t0 * dur + t1 * dur, 16);
	endfunction

	function automatic void sample_vec(input beat_t q, output sample_t o, output bit bad);
		int koff, cnt, voff, idx, t, c, b;
		bit cubic;
		logic [31:0] first, last, ct, nt;
		longint r [3];
		longint unsigned dur, num;
		longint fr, p0, p1;
		koff = q.koff; cnt = q.kcnt; voff = q.voff;
		cubic = (q.mode == MODE_CUBIC);
		bad = 1'b0;
		o = '0;
		r[0] = 0; r[1] = 0; r[2] = 0;
		if (cnt == 0) return;
		first = key_rd(koff, bad);
		if (cnt == 1 || q.stime <= first) begin
			idx = voff + (cubic ? 1 : 0);
			for (c = 0; c < 3; c++) r[c] = comp_rd(idx, c, bad);
			o.fnd = 1'b1;
		end else begin
			last = key_rd(koff + cnt - 1, bad);
			if (q.stime >= last) begin
				idx = voff + (cubic ? (cnt - 1) * 3 + 1 : cnt - 1);
				for (c = 0; c < 3; c++) r[c] = comp_rd(idx, c, bad);
				o.fnd = 1'b1;
			end else begin
				for (t = 0; t + 1 < cnt; t++) begin
					ct = key_rd(koff + t, bad);
					nt = key_rd(koff + t + 1, bad);
					if (ct <= q.stime && nt > q.stime) begin
						dur = 64'(nt - ct);
						num = 64'(q.stime - ct) << FRACT_BITS;
						fr = (dur == 0) ? 0 : longint'(num / dur);
						o.fnd = 1'b1;
						for (c = 0; c < 3; c++) begin
							case (q.mode)
								MODE_LINEAR: begin
									p0 = comp_rd(voff + t, c, bad);
									p1 = comp_rd(voff + t + 1, c, bad);
									r[c] = p0 + rnd_shift((p1 - p0) * fr, FRACT_BITS);
								end
								MODE_STEP: r[c] = comp_rd(voff + t, c, bad);
								MODE_CUBIC: begin
									b = voff + t * 3;
									r[c] = hermite_eval(comp_rd(b + 1, c, bad),
										comp_rd(b + 2, c, bad), comp_rd(b + 4, c, bad),
										comp_rd(b + 3, c, bad), fr, longint'(dur));
								end
								default: begin
									r[c] = 0;
									o.fnd = 1'b0;
								end
							endcase
						end
						break;
					end
				end
			end
		end
		o.x = clamp32(r[0]);
		o.y = clamp32(r[1]);
		o.z = clamp32(r[2]);
	endfunction

	// ---------------- beat builders ----------------
	function automatic beat_t blank_beat();
		beat_t b;
		b.kind = KIND_QUERY; b.addr = '0; b.ltime = '0; b.lx = '0; b.ly = '0; b.lz = '0;
		b.koff = '0; b.kcnt = 11'd1; b.voff = '0; b.mode = MODE_LINEAR; b.stime = '0;
		return b;
	endfunction

	function automatic beat_t time_beat(input int a, input logic [31:0] t);
		beat_t b;
		b = blank_beat();
		b.kind = KIND_TIME; b.addr = 12'(a); b.ltime = t;
		b.stime = $urandom; b.koff = 10'($urandom);
		return b;
	endfunction

	function automatic beat_t vec_beat(input int a, input logic [31:0] x, y, z);
		beat_t b;
		b = blank_beat();
		b.kind = KIND_VALUE; b.addr = 12'(a); b.lx = x; b.ly = y; b.lz = z;
		b.ltime = $urandom;
		return b;
	endfunction

	function automatic beat_t query_beat(input int ko, kc, vo, input logic [1:0] md,
			input logic [31:0] tm);
		beat_t b;
		b = blank_beat();
		b.koff = 10'(ko); b.kcnt = 11'(kc); b.voff = 12'(vo); b.mode = md; b.stime = tm;
		b.addr = 12'($urandom); b.lx = $urandom;
		return b;
	endfunction

	function automatic sample_t smp(input logic [31:0] x, y, z, input logic f);
		sample_t s;
		s.x = x; s.y = y; s.z = z; s.fnd = f;
		return s;
	endfunction

	function automatic logic [31:0] rnd_value();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
			3, 4, 5: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
		endcase
	endfunction

	// ---------------- driver ----------------
	// item_valid stays high after a beat; the next send or drain sets it
	task automatic send(input beat_t b, input bit typed = 1'b0, input sample_t res = '0);
		sample_t p;
		bit bad;
		if (b.kind == KIND_QUERY) sample_vec(b, p, bad);
		while ($urandom_range(99) < src_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= b.kind; address <= b.addr; load_time <= b.ltime;
		load_x <= b.lx; load_y <= b.ly; load_z <= b.lz;
		key_offset <= b.koff; key_count <= b.kcnt; value_offset <= b.voff;
		interp_mode <= b.mode; sample_time <= b.stime;
		do @(posedge clk); while (!item_ready);
		case (b.kind)
			KIND_TIME: begin
				n_loads++;
				n_sent++;
				if (b.addr < TIME_DEPTH) begin
					key_time_mem[b.addr] = b.ltime;
					time_set[b.addr] = 1'b1;
				end
			end
			KIND_VALUE: begin
				n_loads++;
				n_sent++;
				vec_mem[b.addr][0] = b.lx;
				vec_mem[b.addr][1] = b.ly;
				vec_mem[b.addr][2] = b.lz;
				vec_set[b.addr] = 1'b1;
			end
			KIND_QUERY: begin
				n_queries++;
				n_sent++;
				if (b.mode == MODE_CUBIC) n_cubic++;
				pending_samples.push_back(typed ? res : p);
			end
			default: ;
		endcase
	endtask

	task automatic try_query(input beat_t q);
		sample_t p;
		bit bad;
		sample_vec(q, p, bad);
		if (!bad) send(q);
	endtask

	// one channel written with mostly sorted keys, then queried around its keys
	task automatic build_channel();
		int koff, cnt, voff, nv, nq, i;
		logic [1:0] md, qm;
		logic [31:0] t, tfirst, tlast, tm, lo, hi;
		md = 2'($urandom_range(2));
		cnt = ($urandom_range(99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 48);
		koff = $urandom_range(1023);
		voff = $urandom_range(4095);
		nv = (md == MODE_CUBIC) ? 3 * cnt : cnt;
		t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
		tfirst = t;
		for (i = 0; i < cnt; i++) begin
			send(time_beat(koff + i, t));
			tlast = t;
			case ($urandom_range(19))
				0: t = t;
				1: t = t + $urandom;
				2: t = t - $urandom_range(1, 32'h0002_0000);
				default: t = t + $urandom_range(1, 32'h0003_0000);
			endcase
		end
		for (i = 0; i < nv && voff + i < VALUE_DEPTH; i++)
			send(vec_beat(voff + i, rnd_value(), rnd_value(), rnd_value()));
		nq = $urandom_range(2, 6);
		for (i = 0; i < nq; i++) begin
			qm = ($urandom_range(99) < 85) ? md : 2'($urandom_range(3));
			lo = (tfirst > 32'h8000) ? tfirst - 32'h8000 : 32'd0;
			hi = (tlast < 32'hFFFF_0000) ? tlast + 32'h8000 : tlast;
			case ($urandom_range(9))
				0: tm = $urandom;
				1: tm = tfirst;
				2: tm = tlast;
				default: tm = (hi >= lo) ? $urandom_range(lo, hi) : $urandom;
			endcase
			try_query(query_beat(koff, cnt, voff, qm, tm));
		end
	endtask

	task automatic noise_beat();
		beat_t b;
		case ($urandom_range(4))
			0: begin
				b = time_beat($urandom_range(4095), $urandom);
				b.kind = 2'd3;
				send(b);
			end
			1: send(time_beat($urandom_range(4095), $urandom));
			2: send(vec_beat($urandom_range(4095), rnd_value(), rnd_value(), rnd_value()));
			default: try_query(query_beat($urandom_range(1023), $urandom_range(0, 1024),
				$urandom_range(4095), 2'($urandom_range(3)), $urandom));
		endcase
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		wait (pending_samples.size() == 0);
		@(posedge clk);
	endtask

	task automatic random_phase(input int target, input int src, input int snk);
		int stop_at, pause_at;
		src_idle = src;
		snk_idle = snk;
		stop_at = n_sent + target;
		pause_at = n_sent + target / 2;
		while (n_sent < stop_at) begin
			if ($urandom_range(99) < 75) build_channel();
			else noise_beat();
			if (n_sent >= pause_at) begin
				drain();
				pause_at = stop_at + 1;
			end
		end
		drain();
	endtask

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		sample_t e;
		if (arst_n && result_valid && result_ready) begin
			if (pending_samples.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= SHOW_MAX)
					$display("ERROR: unexpected result beat x=%h y=%h z=%h found=%b",
						out_x, out_y, out_z, found);
			end else begin
				e = pending_samples.pop_front();
				n_checked++;
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z || found !== e.fnd) begin
					n_mismatch++;
					if (n_mismatch <= SHOW_MAX)
						$display("ERROR: result %0d exp x=%h y=%h z=%h f=%b got x=%h y=%h z=%h f=%b",
							n_checked, e.x, e.y, e.z, e.fnd, out_x, out_y, out_z, found);
				end
			end
		end
		result_ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycles,
				pending_samples.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------- directed table and run ----------------
	task automatic fill_table();
		directed.push_back('{time_beat(0, 32'h0001_0000), 0, '0});
		directed.push_back('{time_beat(1, 32'h0002_0000), 0, '0});
		directed.push_back('{time_beat(2, 32'h0003_0000), 0, '0});
		directed.push_back('{time_beat(1023, 32'h0001_0000), 0, '0});
		directed.push_back('{time_beat(1024, 32'hFFFF_FFFF), 0, '0});   // ignored address
		directed.push_back('{vec_beat(0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF), 0, '0});
		directed.push_back('{vec_beat(1, 32'h0003_0000, 32'h0001_0000, 32'h8000_0000), 0, '0});
		directed.push_back('{vec_beat(2, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001), 0, '0});
		directed.push_back('{vec_beat(3, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000), 0, '0});
		directed.push_back('{vec_beat(4, 32'hFFFF_8000, 32'h0004_0000, 32'h7FFF_FFFF), 0, '0});
		directed.push_back('{vec_beat(4095, 32'h1234_5678, 32'h8765_4321, 32'h0), 0, '0});
		directed.push_back('{query_beat(0, 0, 0, MODE_LINEAR, 32'h0001_8000), 1,
			smp(0, 0, 0, 1'b0)});
		directed.push_back('{query_beat(0, 1, 0, MODE_LINEAR, 32'hFFFF_FFFF), 1,
			smp(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1)});
		directed.push_back('{query_beat(0, 3, 0, MODE_LINEAR, 32'h0), 1,
			smp(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1)});
		directed.push_back('{query_beat(0, 3, 0, MODE_LINEAR, 32'hFFFF_FFFF), 1,
			smp(32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1)});
		directed.push_back('{query_beat(0, 3, 0, 2'd3, 32'h0000_8000), 1,
			smp(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1)});
		directed.push_back('{query_beat(0, 3, 0, 2'd3, 32'h0001_8000), 1,
			smp(0, 0, 0, 1'b0)});
		directed.push_back('{query_beat(0, 3, 0, MODE_STEP, 32'h0001_8000), 1,
			smp(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1)});
		directed.push_back('{query_beat(0, 3, 0, MODE_LINEAR, 32'h0001_8000), 0, '0});
		directed.push_back('{query_beat(0, 2, 0, MODE_CUBIC, 32'h0001_4000), 0, '0});
		directed.push_back('{query_beat(0, 2, 0, MODE_CUBIC, 32'h0000_0000), 1,
			smp(32'h0003_0000, 32'h0001_0000, 32'h8000_0000, 1'b1)});
		directed.push_back('{query_beat(0, 2, 0, MODE_CUBIC, 32'h0002_0000), 1,
			smp(32'hFFFF_8000, 32'h0004_0000, 32'h7FFF_FFFF, 1'b1)});
		// last key lies past the time store and reads as zero
		directed.push_back('{query_beat(1023, 2, 0, MODE_LINEAR, 32'h0002_0000), 1,
			smp(32'h0003_0000, 32'h0001_0000, 32'h8000_0000, 1'b1)});
		directed.push_back('{query_beat(1023, 2, 4095, MODE_LINEAR, 32'h0002_0000), 1,
			smp(0, 0, 0, 1'b1)});
		directed.push_back('{query_beat(1023, 1024, 4095, MODE_CUBIC, 32'h0), 1,
			smp(0, 0, 0, 1'b1)});
		directed.push_back('{query_beat(1023, 1024, 4095, MODE_LINEAR, 32'h0), 1,
			smp(32'h1234_5678, 32'h8765_4321, 32'h0, 1'b1)});
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid <= 1'b0;
		kind <= KIND_TIME; address <= '0; load_time <= '0;
		load_x <= '0; load_y <= '0; load_z <= '0;
		key_offset <= '0; key_count <= '0; value_offset <= '0;
		interp_mode <= MODE_LINEAR; sample_time <= '0;
		result_ready <= 1'b0;
		src_idle = 0; snk_idle = 0;
		n_sent = 0; n_loads = 0; n_queries = 0; n_checked = 0; n_cubic = 0;
		n_mismatch = 0; cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_table();
		src_idle = 19;
		snk_idle = 83;
		foreach (directed[i]) send(directed[i].b, directed[i].typed, directed[i].res);
		drain();

		random_phase(460, 19, 83);
		random_phase(460, 83, 19);
		random_phase(460, 0, 0);

		repeat (200) @(posedge clk);
		$display("Covered %0d load beats and %0d queries (%0d cubic), %0d results checked",
			n_loads, n_queries, n_cubic, n_checked);
		$display("Idle patterns: sender-light/receiver-heavy, reversed, and none");
		if (n_mismatch == 0 && pending_samples.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results missing", n_mismatch, pending_samples.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
design/kvs_pkg.sv
design/kvs_ram.sv
design/kvs_dp.sv
design/kvs_ctrl.sv
design/keyframe_vector_sampler.sv
design/kvs_checker.sv
test/testbench.sv
